FILE: rtl/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// shared types and constants of the command packet deframer
// ----------------------------------------------------------------------------
package cpd_pkg;

   localparam int WORD_BITS   = 32;
   localparam int REMAIN_BITS = 24;
   localparam int OPCODE_BITS = 8;
   localparam int LEN_BITS    = 15;
   localparam int INDEX_BITS  = 14;
   localparam int KIND_BITS   = 2;

   // beat kinds
   localparam logic [KIND_BITS-1:0] KIND_HEADER  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_BAD     = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_DISCARD = 2'd3;

   // header type codes in bits 31:30
   localparam logic [1:0] HDR_TYPE_ZERO  = 2'd0;
   localparam logic [1:0] HDR_TYPE_THREE = 2'd3;

   // packet length words beyond the length field (header plus one)
   localparam logic [LEN_BITS-1:0] LEN_EXTRA = 15'd2;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic                   packet_type;
      logic [OPCODE_BITS-1:0] opcode;
      logic [LEN_BITS-1:0]    payload_length;
      logic [INDEX_BITS-1:0]  payload_index;
      logic                   end_of_packet;
   } pkt_info_type;

endpackage

FILE: rtl/cpd_decode.sv
// ----------------------------------------------------------------------------
// cpd_decode
// header decode, packet tracking state and running counters
// ----------------------------------------------------------------------------
module cpd_decode #(
   parameter int OFFSET_BITS  = 24,
   parameter int COUNTER_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               resume_after_error,
   input  logic                               advance,
   input  logic [cpd_pkg::WORD_BITS-1:0]      word,
   input  logic [cpd_pkg::REMAIN_BITS-1:0]    words_remaining,
   output cpd_pkg::pkt_info_type              info,
   output logic [OFFSET_BITS-1:0]             buffer_offset,
   output logic [COUNTER_BITS-1:0]            packets_total,
   output logic [COUNTER_BITS-1:0]            words_total,
   output logic [COUNTER_BITS-1:0]            errors_total
);
   import cpd_pkg::*;

   logic [LEN_BITS-1:0]     left_ff,  left_in;
   logic [OPCODE_BITS-1:0]  opcode_ff, opcode_in;
   logic                    type_ff,  type_in;
   logic [LEN_BITS-1:0]     plen_ff,  plen_in;
   logic                    drop_ff,  drop_in;
   logic [OFFSET_BITS-1:0]  offset_ff, offset_in;
   logic [COUNTER_BITS-1:0] pkt_ff,   pkt_in;
   logic [COUNTER_BITS-1:0] wrd_ff,   wrd_in;
   logic [COUNTER_BITS-1:0] err_ff,   err_in;

   logic                    last;
   logic [1:0]              tbits;
   logic [LEN_BITS-1:0]     total;
   logic                    valid_type;
   logic                    bad;

   assign last       = (words_remaining <= REMAIN_BITS'(1));
   assign tbits      = word[31:30];
   assign total      = {1'b0, word[29:16]} + LEN_EXTRA;
   assign valid_type = (tbits == HDR_TYPE_ZERO) || (tbits == HDR_TYPE_THREE);
   assign bad        = !valid_type || (REMAIN_BITS'(total) > words_remaining);

   always_comb begin
      info      = '0;
      left_in   = left_ff;
      opcode_in = opcode_ff;
      type_in   = type_ff;
      plen_in   = plen_ff;
      drop_in   = drop_ff;
      pkt_in    = pkt_ff;
      wrd_in    = wrd_ff;
      err_in    = err_ff;

      if (drop_ff) begin
         info.kind = KIND_DISCARD;
      end else if (left_ff != '0) begin
         info.kind           = KIND_PAYLOAD;
         info.packet_type    = type_ff;
         info.opcode         = opcode_ff;
         info.payload_length = plen_ff;
         info.payload_index  = INDEX_BITS'(plen_ff - left_ff);
         info.end_of_packet  = (left_ff == LEN_BITS'(1));
         left_in             = left_ff - LEN_BITS'(1);
      end else if (bad) begin
         info.kind = KIND_BAD;
         err_in    = err_ff + COUNTER_BITS'(1);
         if (!resume_after_error) begin
            drop_in = 1'b1;
         end
      end else begin
         type_in   = (tbits == HDR_TYPE_THREE);
         opcode_in = (tbits == HDR_TYPE_THREE) ? word[15:8] : '0;
         plen_in   = total - LEN_BITS'(1);
         left_in   = total - LEN_BITS'(1);
         pkt_in    = pkt_ff + COUNTER_BITS'(1);
         wrd_in    = wrd_ff + COUNTER_BITS'(total);
         info.kind           = KIND_HEADER;
         info.packet_type    = type_in;
         info.opcode         = opcode_in;
         info.payload_length = plen_in;
      end

      // buffer end restarts framing
      if (last) begin
         offset_in = '0;
         drop_in   = 1'b0;
         left_in   = '0;
      end else begin
         offset_in = offset_ff + OFFSET_BITS'(1);
      end
   end

   assign buffer_offset = offset_ff;
   assign packets_total = pkt_in;
   assign words_total   = wrd_in;
   assign errors_total  = err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         opcode_ff <= '0;
         type_ff   <= 1'b0;
         plen_ff   <= '0;
         drop_ff   <= 1'b0;
         offset_ff <= '0;
         pkt_ff    <= '0;
         wrd_ff    <= '0;
         err_ff    <= '0;
      end else if (advance) begin
         left_ff   <= left_in;
         opcode_ff <= opcode_in;
         type_ff   <= type_in;
         plen_ff   <= plen_in;
         drop_ff   <= drop_in;
         offset_ff <= offset_in;
         pkt_ff    <= pkt_in;
         wrd_ff    <= wrd_in;
         err_ff    <= err_in;
      end
   end

endmodule

FILE: rtl/command_packet_deframer_unit.sv
// ----------------------------------------------------------------------------
// command_packet_deframer_unit
// splits a command word stream into packet headers, payload and error beats
// ----------------------------------------------------------------------------
// path: a req beat passes through the input register and the output register
//    before it shows as a valid rsp beat
// throughput: one beat per cycle while rsp_tready holds no beat back, set by
//    the single decode stage between the input register and the output register
// reset: synchronous, clears framing state, counters, offset and the
//    resume_after_error register; no beats are held after reset
module command_packet_deframer_unit #(
   parameter int OFFSET_BITS  = 24,
   parameter int COUNTER_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,

   // configuration: resume_after_error
   input  logic        csr_we,
   input  logic        csr_wdata,

   // command words in
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] word, [55:32] words_remaining
   input  logic [55:0] req_tdata,

   // decoded beats out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // opcode, payload_length, payload_index, data_word, buffer_offset,
   // packets_total, words_total, errors_total (lowest bit up), zero padded
   output logic [((69 + OFFSET_BITS + 3 * COUNTER_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // [1:0] kind, [2] packet_type
   output logic [2:0]  rsp_tuser,
   // end_of_packet
   output logic        rsp_tlast
);
   import cpd_pkg::*;

   localparam int RSP_RAW_BITS  = OPCODE_BITS + LEN_BITS + INDEX_BITS + WORD_BITS
                                  + OFFSET_BITS + 3 * COUNTER_BITS;
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8;

   // configuration register
   logic resume_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         resume_ff <= 1'b0;
      end else if (csr_we) begin
         resume_ff <= csr_wdata;
      end
   end

   // input register
   logic                   in_valid_ff;
   logic [WORD_BITS-1:0]   in_word_ff;
   logic [REMAIN_BITS-1:0] in_rem_ff;
   logic                   out_free;
   logic                   advance;

   // output register takes a beat when empty or being drained
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_word_ff <= req_tdata[WORD_BITS-1:0];
         in_rem_ff  <= req_tdata[WORD_BITS +: REMAIN_BITS];
      end
   end

   // decode stage with framing state
   pkt_info_type            info;
   logic [OFFSET_BITS-1:0]  offset;
   logic [COUNTER_BITS-1:0] packets;
   logic [COUNTER_BITS-1:0] words;
   logic [COUNTER_BITS-1:0] errors;

   cpd_decode #(
      .OFFSET_BITS  (OFFSET_BITS),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_decode (
      .clock              (clock),
      .reset              (reset),
      .resume_after_error (resume_ff),
      .advance            (advance),
      .word               (in_word_ff),
      .words_remaining    (in_rem_ff),
      .info               (info),
      .buffer_offset      (offset),
      .packets_total      (packets),
      .words_total        (words),
      .errors_total       (errors)
   );

   // output register
   logic                     out_valid_ff;
   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;
   logic [2:0]               out_user_ff, out_user_in;
   logic                     out_last_ff, out_last_in;

   always_comb begin
      out_data_in = RSP_DATA_BITS'({errors, words, packets, offset, in_word_ff,
                                    info.payload_index, info.payload_length,
                                    info.opcode});
      out_user_in = {info.packet_type, info.kind};
      out_last_in = info.end_of_packet;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
